// File: rtl/ppdec_pkg.sv
// ----------------------------------------------------------------------------
// ppdec_pkg
// Shared widths, opcodes and decoded item kinds of the path pair duplicate
// edge check.
// ----------------------------------------------------------------------------
package ppdec_pkg;

	localparam int OP_W      = 2;
	localparam int EDGE_W    = 13;
	localparam int PATH_W    = 16;
	localparam int S_DATA_W  = 16;  // edge_number padded to whole bytes
	localparam int M_DATA_W  = 16;

	localparam int NUM_EDGES_DEF = 4096;

	// Most rows with a flip-flop valid bit each
	localparam int MAX_ROW_IDX_W = 8;

	typedef enum logic [OP_W-1:0] {
		OP_FIRST  = 2'd0,
		OP_SECOND = 2'd1,
		OP_END    = 2'd2
	} op_t;

	// Decoded item held in the input stage
	typedef enum logic [1:0] {
		K_NOP   = 2'd0,
		K_MARK  = 2'd1,
		K_CHECK = 2'd2,
		K_END   = 2'd3
	} kind_t;

endpackage

// File: rtl/path_pair_duplicate_edge_check_top.sv
// ----------------------------------------------------------------------------
// path_pair_duplicate_edge_check_top
// Marks first-part edges in a visited store, checks and marks second-part
// edges, and reports each pair's number with a duplicate-free flag.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; the input stalls only while an end item
//   waits for the output register to be taken.
// Result path: an accepted end item passes the input stage (registered row
//   read), then the result register that drives m_tvalid.
// Reset: control clears at once, the pair counter loads one, and the row
//   valid flip-flops clear the whole store with no clearing pass.
module path_pair_duplicate_edge_check_top #(
	parameter int NUM_EDGES = ppdec_pkg::NUM_EDGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ppdec_pkg::S_DATA_W-1:0] s_tdata,  // [12:0] edge_number, [15:13] zero
	input  logic [ppdec_pkg::OP_W-1:0]     s_tuser,  // [1:0] opcode
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ppdec_pkg::M_DATA_W-1:0] m_tdata,  // [15:0] path_number
	output logic                          m_tuser   // [0] duplicate_free
);
	import ppdec_pkg::*;

	localparam int SLOT_W    = (NUM_EDGES > 1) ? $clog2(NUM_EDGES) : 1;
	localparam int ROW_IDX_W = (SLOT_W < MAX_ROW_IDX_W) ? SLOT_W : MAX_ROW_IDX_W;
	localparam int ROW_LOG   = SLOT_W - ROW_IDX_W;
	localparam int ROWS      = 1 << ROW_IDX_W;
	localparam int ROW_BITS  = 1 << ROW_LOG;
	localparam int BIT_W     = (ROW_LOG > 0) ? ROW_LOG : 1;

	// Input decode
	logic [EDGE_W-1:0]    edge_in;
	logic [31:0]          slot_full;
	logic                 in_range;
	kind_t                kind_in;
	logic [ROW_IDX_W-1:0] row_in;
	logic [BIT_W-1:0]     bit_in;
	logic                 s_accept;

	// Input stage
	logic                 s1_vld;
	kind_t                kind_s1;
	logic [ROW_IDX_W-1:0] row_s1;
	logic [BIT_W-1:0]     bit_s1;
	logic [ROW_BITS-1:0]  rd_s1;
	logic                 fwd_s1;
	logic [ROW_BITS-1:0]  fwd_row_s1;

	// Store and pair state
	logic [ROW_BITS-1:0]  mem [ROWS];
	logic [ROWS-1:0]      row_vld_q;
	logic                 dup_q;
	logic [PATH_W-1:0]    cnt_q;

	// Result register
	logic                 m_vld_q;
	logic [PATH_W-1:0]    m_path_q;
	logic                 m_free_q;

	// Stage logic
	logic                 s1_go;
	logic                 end_go;
	logic                 wr_en;
	logic                 fwd_nxt;
	logic [ROW_BITS-1:0]  row_eff;
	logic [ROW_BITS-1:0]  bit_mask;
	logic [ROW_BITS-1:0]  row_new;
	logic                 hit;

	assign edge_in   = s_tdata[EDGE_W-1:0];
	assign slot_full = 32'(edge_in) - 32'd1;
	assign in_range  = (edge_in != '0) && (32'(edge_in) <= 32'(NUM_EDGES));
	assign row_in    = ROW_IDX_W'(slot_full >> ROW_LOG);
	assign bit_in    = BIT_W'(slot_full & 32'(ROW_BITS - 1));

	always_comb begin
		case (s_tuser)
			OP_FIRST:  kind_in = in_range ? K_MARK : K_NOP;
			OP_SECOND: kind_in = in_range ? K_CHECK : K_NOP;
			OP_END:    kind_in = K_END;
			default:   kind_in = K_NOP;
		endcase
	end

	// An end item leaves only when the result register can take it
	assign s1_go    = s1_vld && ((kind_s1 != K_END) || !m_vld_q || m_tready);
	assign s_tready = !s1_vld || s1_go;
	assign s_accept = s_tvalid && s_tready;
	assign end_go   = s1_go && (kind_s1 == K_END);
	assign wr_en    = s1_go && ((kind_s1 == K_MARK) || (kind_s1 == K_CHECK));

	// Take the row being written now when the next item reads the same row
	assign row_eff  = fwd_s1 ? fwd_row_s1 : (row_vld_q[row_s1] ? rd_s1 : '0);
	assign bit_mask = ROW_BITS'(1) << bit_s1;
	assign row_new  = row_eff | bit_mask;
	assign hit      = |(row_eff & bit_mask);
	assign fwd_nxt  = wr_en && (row_s1 == row_in);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[row_s1] <= row_new;
		end
		if (s_accept) begin
			rd_s1 <= mem[row_in];
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			kind_s1    <= kind_in;
			row_s1     <= row_in;
			bit_s1     <= bit_in;
			fwd_row_s1 <= row_new;
		end
		if (end_go) begin
			m_path_q <= cnt_q;
			m_free_q <= !dup_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld    <= 1'b0;
			fwd_s1    <= 1'b0;
			row_vld_q <= '0;
			dup_q     <= 1'b0;
			cnt_q     <= PATH_W'(1);
			m_vld_q   <= 1'b0;
		end else begin
			if (s_accept) begin
				s1_vld <= 1'b1;
				fwd_s1 <= fwd_nxt;
			end else if (s1_go) begin
				s1_vld <= 1'b0;
				fwd_s1 <= 1'b0;
			end

			if (end_go) begin
				// drop every mark and start the next pair
				row_vld_q <= '0;
				dup_q     <= 1'b0;
				cnt_q     <= cnt_q + PATH_W'(1);
			end else if (wr_en) begin
				row_vld_q[row_s1] <= 1'b1;
				if ((kind_s1 == K_CHECK) && hit) begin
					dup_q <= 1'b1;
				end
			end

			if (end_go) begin
				m_vld_q <= 1'b1;
			end else if (m_tready) begin
				m_vld_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_vld_q;
	assign m_tdata  = M_DATA_W'(m_path_q);
	assign m_tuser  = m_free_q;

	// A new result comes only from an end item leaving the input stage
	a_result_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(end_go))
		else $error("result without end item");

	// Forwarding only ever follows a store write
	a_fwd_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && fwd_nxt) |=> (fwd_s1 && s1_vld))
		else $error("forward flag lost");

	// The store reads empty after an end item
	a_clear_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		end_go |=> ((row_vld_q == '0) && !dup_q && !fwd_s1))
		else $error("store not cleared at end of pair");

	// The pair counter advances by one per result
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		end_go |=> (cnt_q == $past(cnt_q) + PATH_W'(1)))
		else $error("pair counter skipped");

endmodule

// File: dv/ppdec_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ppdec_result_checker
// Watches both streams of the path pair duplicate edge check, tracks the
// visited-edge store from each accepted item and compares every pair result
// with the oldest one still owed.
// ----------------------------------------------------------------------------
module ppdec_result_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [ppdec_pkg::S_DATA_W-1:0] s_tdata,  // [12:0] edge_number, [15:13] zero
	input  logic [ppdec_pkg::OP_W-1:0]     s_tuser,  // [1:0] opcode
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [ppdec_pkg::M_DATA_W-1:0] m_tdata,  // [15:0] path_number
	input  logic                           m_tuser,  // [0] duplicate_free
	output int unsigned                    mismatches,
	output int unsigned                    results_owed
);
	import ppdec_pkg::*;

	localparam int SLOT_W = $clog2(NUM_EDGES_DEF);

	typedef struct packed {
		logic [PATH_W-1:0] path_number;
		logic              duplicate_free;
	} pair_result_t;

	bit [NUM_EDGES_DEF-1:0] visited;
	bit                     dup_found;
	logic [PATH_W-1:0]      pair_num;
	pair_result_t           owed_pair_results[$];
	int unsigned            fail_count;

	task automatic predict_pair_result(input logic [OP_W-1:0] op,
			input logic [EDGE_W-1:0] edge_num);
		pair_result_t      res;
		logic [SLOT_W-1:0] slot;
		case (op)
			OP_FIRST, OP_SECOND: begin
				// drop edges outside 1..NUM_EDGES
				if (edge_num >= 1 && edge_num <= NUM_EDGES_DEF) begin
					slot = SLOT_W'(edge_num - 1'b1);
					if (op == OP_SECOND && visited[slot])
						dup_found = 1'b1;
					visited[slot] = 1'b1;
				end
			end
			OP_END: begin
				res.path_number    = pair_num;
				res.duplicate_free = !dup_found;
				owed_pair_results.push_back(res);
				visited   = '0;
				dup_found = 1'b0;
				pair_num  = pair_num + 1'b1;
			end
			default: ;
		endcase
	endtask

	task automatic check_pair_result(input logic [PATH_W-1:0] path_number,
			input logic duplicate_free);
		pair_result_t exp_res;
		if (owed_pair_results.size() == 0) begin
			fail_count++;
			$display("%0t: result with none owed: path_number %0d duplicate_free %0d",
				$time, path_number, duplicate_free);
		end else begin
			exp_res = owed_pair_results.pop_front();
			if (path_number !== exp_res.path_number) begin
				fail_count++;
				$display("%0t: path_number expected %0d, actual %0d",
					$time, exp_res.path_number, path_number);
			end
			if (duplicate_free !== exp_res.duplicate_free) begin
				fail_count++;
				$display("%0t: duplicate_free of pair %0d expected %0d, actual %0d",
					$time, exp_res.path_number, exp_res.duplicate_free, duplicate_free);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited    = '0;
			dup_found  = 1'b0;
			pair_num   = PATH_W'(1);
			fail_count = 0;
			owed_pair_results.delete();
			mismatches   <= 0;
			results_owed <= 0;
		end else begin
			if (s_tvalid && s_tready)
				predict_pair_result(s_tuser, s_tdata[EDGE_W-1:0]);
			if (m_tvalid && m_tready)
				check_pair_result(m_tdata[PATH_W-1:0], m_tuser);
			mismatches   <= fail_count;
			results_owed <= owed_pair_results.size();
		end
	end

endmodule

// File: dv/path_pair_duplicate_edge_check_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// path_pair_duplicate_edge_check_top_tb
// Drives path pairs into the duplicate edge check: directed corner pairs,
// random pairs with stray items and random idling on both streams, then a
// tail of random pairs with no idling. The checker predicts and compares
// every result.
// ----------------------------------------------------------------------------
module path_pair_duplicate_edge_check_top_tb;
	import ppdec_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;
	localparam int              EDGE_MAX_RAW = (1 << EDGE_W) - 1;
	localparam int              TOTAL_ITEMS  = 1950;
	localparam int              TAIL_ITEMS   = 300;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata;
	logic [OP_W-1:0]       s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  m_tuser;
	int unsigned           mismatches;
	int unsigned           results_owed;

	bit                    quiet         = 1'b0;
	int                    send_idle_pct = 0;
	int                    stall_pct     = 0;
	int unsigned           items_sent    = 0;
	int unsigned           pairs_sent    = 0;

	always #5 clk = ~clk;

	path_pair_duplicate_edge_check_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	ppdec_result_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.mismatches   (mismatches),
		.results_owed (results_owed)
	);

	task automatic send_item(input logic [OP_W-1:0] op, input logic [EDGE_W-1:0] edge_num);
		if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{(S_DATA_W - EDGE_W){1'b0}}, edge_num};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	function automatic logic [EDGE_W-1:0] stray_edge();
		if ($urandom_range(0, 3) == 0)
			return '0;
		return EDGE_W'($urandom_range(NUM_EDGES_DEF + 1, EDGE_MAX_RAW));
	endfunction

	task automatic send_stray();
		case ($urandom_range(0, 2))
			0:       send_item(OP_UNUSED, EDGE_W'($urandom_range(0, EDGE_MAX_RAW)));
			1:       send_item(OP_FIRST, stray_edge());
			default: send_item(OP_SECOND, stray_edge());
		endcase
	endtask

	// Narrow edge windows make repeats likely; the full window makes them rare.
	task automatic drive_random_pair();
		int span;
		int base;
		int n_first;
		int n_second;
		if ($urandom_range(0, 19) == 0) begin
			// broken pair: any opcode, any raw edge value
			repeat ($urandom_range(1, 10))
				send_item(OP_W'($urandom_range(0, 3)), EDGE_W'($urandom_range(0, EDGE_MAX_RAW)));
		end else begin
			span     = ($urandom_range(0, 3) == 0) ? NUM_EDGES_DEF : $urandom_range(2, 48);
			base     = $urandom_range(1, NUM_EDGES_DEF - span + 1);
			n_first  = $urandom_range(0, 8);
			n_second = $urandom_range(0, 8);
			repeat (n_first) begin
				send_item(OP_FIRST, EDGE_W'(base + $urandom_range(0, span - 1)));
				if ($urandom_range(0, 15) == 0)
					send_stray();
			end
			repeat (n_second) begin
				send_item(OP_SECOND, EDGE_W'(base + $urandom_range(0, span - 1)));
				if ($urandom_range(0, 15) == 0)
					send_stray();
				else if ($urandom_range(0, 9) == 0)
					send_item(OP_FIRST, EDGE_W'(base + $urandom_range(0, span - 1)));
			end
		end
		send_item(OP_END, EDGE_W'($urandom_range(0, EDGE_MAX_RAW)));
		pairs_sent++;
	endtask

	// Receiver: ready stretches and stall bursts
	initial begin
		m_tready <= 1'b0;
		forever begin
			if (quiet || $urandom_range(0, 99) >= stall_pct) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
		end
	end

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= OP_FIRST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 30;
		stall_pct     = 30;

		// empty pair
		send_item(OP_END, '0);
		// repeats within the first part stay clean; edge extremes
		send_item(OP_FIRST, EDGE_W'(1));
		send_item(OP_FIRST, EDGE_W'(NUM_EDGES_DEF));
		send_item(OP_FIRST, EDGE_W'(1));
		send_item(OP_SECOND, EDGE_W'(2));
		send_item(OP_END, EDGE_W'(EDGE_MAX_RAW));
		// second part hits the first part
		send_item(OP_FIRST, EDGE_W'(NUM_EDGES_DEF));
		send_item(OP_SECOND, EDGE_W'(NUM_EDGES_DEF));
		send_item(OP_END, '0);
		// repeat within the second part
		send_item(OP_SECOND, EDGE_W'(100));
		send_item(OP_SECOND, EDGE_W'(100));
		send_item(OP_END, '0);
		// out-of-range edges and the unused opcode leave the store alone
		send_item(OP_FIRST, '0);
		send_item(OP_FIRST, EDGE_W'(NUM_EDGES_DEF + 1));
		send_item(OP_FIRST, EDGE_W'(EDGE_MAX_RAW));
		send_item(OP_SECOND, '0);
		send_item(OP_SECOND, EDGE_W'(EDGE_MAX_RAW));
		send_item(OP_SECOND, EDGE_W'(NUM_EDGES_DEF + 1));
		send_item(OP_UNUSED, EDGE_W'(5));
		send_item(OP_SECOND, EDGE_W'(5));
		send_item(OP_END, '0);
		// first-part edge after the second part only marks
		send_item(OP_SECOND, EDGE_W'(7));
		send_item(OP_FIRST, EDGE_W'(7));
		send_item(OP_END, '0);
		// store is empty again in the next pair
		send_item(OP_SECOND, EDGE_W'(7));
		send_item(OP_END, '0);

		while (items_sent < TOTAL_ITEMS - TAIL_ITEMS) begin
			if (pairs_sent % 8 == 0) begin
				case ($urandom_range(0, 2))
					0:       send_idle_pct = 0;
					1:       send_idle_pct = 10;
					default: send_idle_pct = 40;
				endcase
				case ($urandom_range(0, 2))
					0:       stall_pct = 0;
					1:       stall_pct = 15;
					default: stall_pct = 50;
				endcase
			end
			drive_random_pair();
		end

		// no idling from here on
		quiet = 1'b1;
		while (items_sent < TOTAL_ITEMS)
			drive_random_pair();
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && results_owed == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#12_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
